>>> rtl/core/rpa_pkg.sv
// Shared types and command and status codes for the page allocator core.
`default_nettype none

package rpa_pkg;

    // Widths of the fixed payload fields.
    localparam int ADDR_W   = 27;
    localparam int STATUS_W = 3;
    localparam int REFOUT_W = 16;

    typedef logic [1:0]          cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Command codes.
    localparam cmd_t CMD_ALLOC  = 2'd0;
    localparam cmd_t CMD_FREE   = 2'd1;
    localparam cmd_t CMD_ADDREF = 2'd2;

    // Status codes.
    localparam status_t ST_OK       = 3'd0;
    localparam status_t ST_NO_PAGE  = 3'd1;
    localparam status_t ST_BAD_ADDR = 3'd2;
    localparam status_t ST_ZERO     = 3'd3;
    localparam status_t ST_MAX      = 3'd4;

endpackage

`default_nettype wire

>>> rtl/core/rpa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module rpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/refcounted_page_allocator_core.sv
// Page allocator with a LIFO free stack and per-page reference counts.
// A word is accepted in the idle state; its result is registered in the execute state once out_stall allows.
// A new word is taken only after the last one has executed, as the two memories are read then written back.
// Reset: the count memory is swept over all NUM_PAGES entries, one entry a cycle, with in_stall high.
// The free stack needs no sweep: entries below the lowest stack depth reached read as reset values.
`default_nettype none

module refcounted_page_allocator_core
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES       = 32768,
    parameter int KERNEL_END_PAGE = 512,
    parameter int FIRST_FREE_PAGE = 576,
    parameter int COUNT_WIDTH     = 16,
    parameter int PAGE_BITS       = 12
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic [1:0]          cmd,
    input  wire logic [ADDR_W-1:0]   addr,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic [STATUS_W-1:0]      status,
    output logic [ADDR_W-1:0]        page_addr,
    output logic                     page_released,
    output logic [REFOUT_W-1:0]      ref_count
);

    localparam int PW        = $clog2(NUM_PAGES);
    localparam int TW        = $clog2(NUM_PAGES + 1);
    localparam int PNW       = ADDR_W - PAGE_BITS;
    localparam int RESET_TOP = (NUM_PAGES > FIRST_FREE_PAGE) ? NUM_PAGES - FIRST_FREE_PAGE : 0;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    // Control registers.
    logic [1:0]    state_reg, state_next;
    logic [PW-1:0] clr_idx_reg, clr_idx_next;
    logic [TW-1:0] top_reg, top_next;
    logic [TW-1:0] lwm_reg, lwm_next;
    logic          out_valid_reg, out_valid_next;

    // Item registers captured at accept.
    cmd_t          cmd_reg;
    logic [PW-1:0] page_reg;
    logic          addr_ok_reg;
    logic          init_hit_reg;
    logic [PW-1:0] init_idx_reg;

    // Result registers.
    status_t             status_reg, status_next;
    logic [ADDR_W-1:0]   paddr_reg, paddr_next;
    logic                rel_reg, rel_next;
    logic [REFOUT_W-1:0] cnt_out_reg, cnt_out_next;

    // Memory ports.
    logic                   cnt_we, cnt_re;
    logic [PW-1:0]          cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
    logic                   stk_we, stk_re;
    logic [PW-1:0]          stk_waddr, stk_raddr;
    logic [PW-1:0]          stk_wdata, stk_rdata;

    // Accept-side decode.
    logic          accept;
    logic [PNW-1:0] pg_num;
    logic [31:0]   pg_wide;
    logic          addr_ok;
    logic [TW-1:0] top_m1;
    logic          init_hit;

    // Execute-side values.
    logic                   fire;
    logic [31:0]            init_sum;
    logic [PW-1:0]          pop_page;
    logic [63:0]            pa_wide;
    logic [COUNT_WIDTH-1:0] cnt_dec, cnt_inc;
    logic [COUNT_WIDTH-1:0] cnt_res;
    logic [63:0]            cnt_wide;
    logic                   stack_room;
    logic [31:0]            clr_wide;

    rpa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (NUM_PAGES)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    rpa_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_PAGES)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (stk_re),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    // Handshake on both channels.
    assign in_stall  = (state_reg != S_IDLE);
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign fire      = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;

    // Address check for free and add-reference.
    assign pg_num  = addr[ADDR_W-1:PAGE_BITS];
    assign pg_wide = 32'(pg_num);
    assign addr_ok = (addr[PAGE_BITS-1:0] == '0)
                     && (pg_wide >= 32'(KERNEL_END_PAGE))
                     && (pg_wide < 32'(NUM_PAGES));

    // Stack entries below the low-water mark were never overwritten since reset.
    assign top_m1   = top_reg - 1'b1;
    assign init_hit = (top_m1 < lwm_reg);

    // Reads are issued as the word is accepted.
    assign cnt_re    = accept;
    assign cnt_raddr = pg_wide[PW-1:0];
    assign stk_re    = accept;
    assign stk_raddr = top_m1[PW-1:0];

    // Popped page and derived values.
    assign init_sum   = 32'(FIRST_FREE_PAGE) + 32'(init_idx_reg);
    assign pop_page   = init_hit_reg ? init_sum[PW-1:0] : stk_rdata;
    assign pa_wide    = 64'(pop_page) << PAGE_BITS;
    assign cnt_dec    = cnt_rdata - 1'b1;
    assign cnt_inc    = cnt_rdata + 1'b1;
    assign stack_room = (32'(top_reg) < 32'(NUM_PAGES));
    assign cnt_wide   = 64'(cnt_res);
    assign clr_wide   = 32'(clr_idx_reg);

    // Count memory sweep, command execution, memory write-back and result formation.
    always_comb
    begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        top_next       = top_reg;
        lwm_next       = lwm_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        paddr_next     = paddr_reg;
        rel_next       = rel_reg;
        cnt_out_next   = cnt_out_reg;
        cnt_we         = 1'b0;
        cnt_waddr      = page_reg;
        cnt_wdata      = '0;
        stk_we         = 1'b0;
        stk_waddr      = top_reg[PW-1:0];
        stk_wdata      = page_reg;
        cnt_res        = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_idx_reg;
                cnt_wdata = (clr_wide < 32'(FIRST_FREE_PAGE)) ? COUNT_WIDTH'(1) : '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_wide == 32'(NUM_PAGES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (fire)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    paddr_next     = '0;
                    rel_next       = 1'b0;
                    case (cmd_reg)
                        CMD_ALLOC:
                        begin
                            if (top_reg == '0)
                            begin
                                status_next = ST_NO_PAGE;
                            end
                            else
                            begin
                                top_next   = top_m1;
                                if (top_m1 < lwm_reg)
                                begin
                                    lwm_next = top_m1;
                                end
                                cnt_we     = 1'b1;
                                cnt_waddr  = pop_page;
                                cnt_wdata  = COUNT_WIDTH'(1);
                                cnt_res    = COUNT_WIDTH'(1);
                                paddr_next = pa_wide[ADDR_W-1:0];
                            end
                        end
                        CMD_FREE:
                        begin
                            if (!addr_ok_reg)
                            begin
                                status_next = ST_BAD_ADDR;
                            end
                            else if (cnt_rdata == '0)
                            begin
                                status_next = ST_ZERO;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_dec;
                                cnt_res   = cnt_dec;
                                if ((cnt_dec == '0) && stack_room)
                                begin
                                    stk_we   = 1'b1;
                                    top_next = top_reg + 1'b1;
                                    rel_next = 1'b1;
                                end
                            end
                        end
                        CMD_ADDREF:
                        begin
                            if (!addr_ok_reg)
                            begin
                                status_next = ST_BAD_ADDR;
                            end
                            else if (cnt_rdata == CNT_MAX)
                            begin
                                status_next = ST_MAX;
                                cnt_res     = cnt_rdata;
                            end
                            else
                            begin
                                cnt_we    = 1'b1;
                                cnt_wdata = cnt_inc;
                                cnt_res   = cnt_inc;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                    cnt_out_next = cnt_wide[REFOUT_W-1:0];
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            top_reg       <= TW'(RESET_TOP);
            lwm_reg       <= TW'(RESET_TOP);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            top_reg       <= top_next;
            lwm_reg       <= lwm_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= cmd;
            page_reg     <= pg_wide[PW-1:0];
            addr_ok_reg  <= addr_ok;
            init_hit_reg <= init_hit;
            init_idx_reg <= top_m1[PW-1:0];
        end
        status_reg  <= status_next;
        paddr_reg   <= paddr_next;
        rel_reg     <= rel_next;
        cnt_out_reg <= cnt_out_next;
    end

    assign status        = status_reg;
    assign page_addr     = paddr_reg;
    assign page_released = rel_reg;
    assign ref_count     = cnt_out_reg;

endmodule

`default_nettype wire
